// File: rtl/gta_pkg.sv
`timescale 1ns / 1ps
// gta_pkg: shared types, codes and constants of the glyph addresser
// no dependencies

package gta_pkg;

	localparam int COORD_W    = 16;   // width of coordinate and area fields
	localparam int SIZE_BITS  = 6;    // width of the font size register
	localparam int BYTE_BITS  = 8;
	localparam int INDEX_BITS = 15;   // 190 * row + column fits here
	localparam int OFFS_BITS  = 22;
	localparam int GB_BITS    = 8;    // width of the byte count of one glyph bitmap

	// register indexes of the configuration port
	localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
	localparam logic [2:0] REG_AREA_WIDTH  = 3'd2;
	localparam logic [2:0] REG_AREA_HEIGHT = 3'd3;
	localparam logic [2:0] REG_FONT_SIZE   = 3'd4;

	localparam logic [BYTE_BITS-1:0] CHAR_END     = 8'h00;
	localparam logic [BYTE_BITS-1:0] CHAR_NEWLINE = 8'd13;
	localparam logic [BYTE_BITS-1:0] LEAD_MIN     = 8'h81;
	localparam logic [BYTE_BITS-1:0] TRAIL_MIN    = 8'h40;
	localparam logic [BYTE_BITS-1:0] TRAIL_GAP    = 8'h7f;
	localparam logic [BYTE_BITS-1:0] TRAIL_HIGH   = 8'h41;
	localparam logic [BYTE_BITS-1:0] CODE_BAD     = 8'hff;
	localparam logic [INDEX_BITS-1:0] ROW_STRIDE  = 15'd190;

	typedef enum logic [1:0] {
		OP_RESTART = 2'd0,
		OP_ASCII   = 2'd1,
		OP_NEWLINE = 2'd2,
		OP_GLYPH   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ASCII = 2'd0,
		KIND_GLYPH = 2'd1,
		KIND_BLANK = 2'd2,
		KIND_FULL  = 2'd3
	} kind_t;

	// one classified item between front and back
	typedef struct packed {
		op_t                   op;
		logic [BYTE_BITS-1:0]  code;
		logic                  glyph_ok;
		logic [INDEX_BITS-1:0] index;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0]   origin_x;
		logic [COORD_W-1:0]   origin_y;
		logic [COORD_W-1:0]   area_width;
		logic [COORD_W-1:0]   area_height;
		logic [SIZE_BITS-1:0] font_size;
	} cfg_t;

	// cursor load on an origin write
	typedef struct packed {
		logic               load_x;
		logic               load_y;
		logic [COORD_W-1:0] value;
	} cur_load_t;

	function automatic logic size_supported(input logic [SIZE_BITS-1:0] size);
		return size inside {6'd12, 6'd16, 6'd24, 6'd32};
	endfunction

	// ceil(size / 8) * size for the sizes with a glyph table
	function automatic logic [GB_BITS-1:0] glyph_bytes(input logic [SIZE_BITS-1:0] size);
		logic [GB_BITS-1:0] gb;
		case (size)
			6'd12:   gb = 8'd24;
			6'd16:   gb = 8'd32;
			6'd24:   gb = 8'd72;
			6'd32:   gb = 8'd128;
			default: gb = 8'd0;
		endcase
		return gb;
	endfunction

endpackage

// File: rtl/gbk_text_layout_glyph_addresser.sv
`timescale 1ns / 1ps
// gbk_text_layout_glyph_addresser: top level, configuration registers and wiring
// depends on gta_pkg, gta_front, gta_queue, gta_back
//
// channel   direction  handshake                     payload
// input     in         push / full                   text_byte
// result    out        empty / pop                   command_kind pos_x pos_y char_code font_offset
// config    in         cfg_wr (no wait)              cfg_index cfg_data
//
// one text byte is taken per cycle while the item queue has room; a result
// reaches the result ports through the item queue and the result register
// the back end places one item per cycle unless a waiting result is not popped:
// wrap test, bound test and the offset multiply all sit in a single step before the result register
// a result waiting on pop stalls the back end only; the front keeps taking
// bytes until the queue fills, then raises full
// reset clears the cursor to the origin, the queue, the lead byte state and
// the result register, and loads the registers with their reset values

module gbk_text_layout_glyph_addresser import gta_pkg::*; #(
	parameter int COORD_BITS  = 16,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// text bytes
	input  logic                 push,
	input  logic [BYTE_BITS-1:0] text_byte,
	output logic                 full,
	// results
	output logic                 empty,
	input  logic                 pop,
	output logic [1:0]           command_kind,
	output logic [COORD_W-1:0]   pos_x,
	output logic [COORD_W-1:0]   pos_y,
	output logic [BYTE_BITS-1:0] char_code,
	output logic [OFFS_BITS-1:0] font_offset,
	// configuration writes
	input  logic                 cfg_wr,
	input  logic [2:0]           cfg_index,
	input  logic [COORD_W-1:0]   cfg_data
);

	cfg_t      cfg_q;
	cur_load_t cur_load;
	logic      q_wr, q_rd, q_full, q_empty;
	item_t     q_wr_item, q_rd_item;
	kind_t     kind;

	// an origin write also moves the matching cursor coordinate
	assign cur_load.load_x = cfg_wr && (cfg_index == REG_ORIGIN_X);
	assign cur_load.load_y = cfg_wr && (cfg_index == REG_ORIGIN_Y);
	assign cur_load.value  = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x    <= '0;
			cfg_q.origin_y    <= '0;
			cfg_q.area_width  <= COORD_W'(240);
			cfg_q.area_height <= COORD_W'(240);
			cfg_q.font_size   <= SIZE_BITS'(16);
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_ORIGIN_X:    cfg_q.origin_x    <= cfg_data;
				REG_ORIGIN_Y:    cfg_q.origin_y    <= cfg_data;
				REG_AREA_WIDTH:  cfg_q.area_width  <= cfg_data;
				REG_AREA_HEIGHT: cfg_q.area_height <= cfg_data;
				REG_FONT_SIZE:   cfg_q.font_size   <= cfg_data[SIZE_BITS-1:0];
				default: ;  // indexes past the list are dropped
			endcase
		end
	end

	// front: byte pairing and classification
	gta_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.text_byte (text_byte),
		.full      (full),
		.q_wr      (q_wr),
		.q_item    (q_wr_item),
		.q_full    (q_full)
	);

	// decoupling queue
	gta_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_item (q_wr_item),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_item (q_rd_item),
		.empty   (q_empty)
	);

	// back: cursor, window tests, glyph offset, result register
	gta_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cur_load     (cur_load),
		.q_empty      (q_empty),
		.q_item       (q_rd_item),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.command_kind (kind),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.char_code    (char_code),
		.font_offset  (font_offset)
	);

	assign command_kind = kind;

endmodule

// File: rtl/gta_queue.sv
`timescale 1ns / 1ps
// gta_queue: small register queue of classified items between front and back
// depends on gta_pkg

module gta_queue import gta_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd_en,
	output item_t rd_item,
	output logic  empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	item_t               slot_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (rd_en) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (wr_en && !rd_en) count_q <= count_q + 1'b1;
			else if (rd_en && !wr_en) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) slot_q[wr_ptr_q] <= wr_item;
	end

endmodule

// File: rtl/gta_front.sv
`timescale 1ns / 1ps
// gta_front: takes text bytes, pairs gbk lead and trail bytes, classifies items
// depends on gta_pkg

module gta_front import gta_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [BYTE_BITS-1:0] text_byte,
	output logic                 full,
	output logic                 q_wr,
	output item_t                q_item,
	input  logic                 q_full
);

	logic                 lead_pending_q;
	logic [BYTE_BITS-1:0] lead_byte_q;
	logic                 accept;
	logic [BYTE_BITS-1:0] col, row;

	assign full   = q_full;
	assign accept = push && !q_full;

	// trail bytes below 0x7f start at column 0, above skip the gap at 0x7f
	assign col = (text_byte < TRAIL_GAP) ? text_byte - TRAIL_MIN : text_byte - TRAIL_HIGH;
	assign row = lead_byte_q - LEAD_MIN;

	always_comb begin
		q_wr            = 1'b0;
		q_item.op       = OP_ASCII;
		q_item.code     = text_byte;
		q_item.glyph_ok = !(text_byte < TRAIL_MIN || text_byte == CODE_BAD
			|| lead_byte_q == CODE_BAD);
		q_item.index    = ROW_STRIDE * INDEX_BITS'(row) + INDEX_BITS'(col);
		if (text_byte == CHAR_END) begin
			q_item.op = OP_RESTART;
			q_wr      = accept;
		end else if (lead_pending_q) begin
			q_item.op = OP_GLYPH;
			q_wr      = accept;
		end else if (text_byte >= LEAD_MIN) begin
			q_wr = 1'b0;
		end else if (text_byte == CHAR_NEWLINE) begin
			q_item.op = OP_NEWLINE;
			q_wr      = accept;
		end else begin
			q_wr = accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
		end else if (accept) begin
			if (text_byte == CHAR_END || lead_pending_q) lead_pending_q <= 1'b0;
			else if (text_byte >= LEAD_MIN) lead_pending_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !lead_pending_q) lead_byte_q <= text_byte;
	end

endmodule

// File: rtl/gta_back.sv
`timescale 1ns / 1ps
// gta_back: cursor, wrap and bound tests, font offset and the result register
// depends on gta_pkg

module gta_back import gta_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  cur_load_t            cur_load,
	input  logic                 q_empty,
	input  item_t                q_item,
	output logic                 q_rd,
	input  logic                 pop,
	output logic                 empty,
	output kind_t                command_kind,
	output logic [COORD_W-1:0]   pos_x,
	output logic [COORD_W-1:0]   pos_y,
	output logic [BYTE_BITS-1:0] char_code,
	output logic [OFFS_BITS-1:0] font_offset
);

	localparam int LIM_BITS = COORD_W + 2;
	localparam int PROD_BITS = INDEX_BITS + GB_BITS;

	logic [COORD_BITS-1:0] cx_q, cy_q;
	logic                  stopped_q, out_valid_q;

	logic [COORD_BITS-1:0] ox, oy, cx1, cy1, cx_nxt, cy_nxt;
	logic [SIZE_BITS-1:0]  fs, half, step;
	logic [LIM_BITS-1:0]   lim_x, lim_y;
	logic                  go, wrap, area_full, emit, stop_nxt;
	kind_t                 kind;
	logic [PROD_BITS-1:0]  prod;

	assign ox   = cfg.origin_x[COORD_BITS-1:0];
	assign oy   = cfg.origin_y[COORD_BITS-1:0];
	assign fs   = cfg.font_size;
	assign half = fs >> 1;
	assign step = (q_item.op == OP_GLYPH) ? fs : half;

	assign go   = !q_empty && (!out_valid_q || pop);
	assign q_rd = go;

	// x + step > left + width, all unsigned with headroom
	assign lim_x = LIM_BITS'(ox) + LIM_BITS'(cfg.area_width);
	assign wrap  = (LIM_BITS'(cx_q) + LIM_BITS'(step)) > lim_x;
	assign cx1   = wrap ? ox : cx_q;
	assign cy1   = wrap ? cy_q + COORD_BITS'(fs) : cy_q;
	assign lim_y = LIM_BITS'(oy) + LIM_BITS'(cfg.area_height);
	assign area_full = (LIM_BITS'(cy1) + LIM_BITS'(fs)) > lim_y;

	assign prod = PROD_BITS'(q_item.index) * PROD_BITS'(glyph_bytes(fs));

	always_comb begin
		cx_nxt   = cx_q;
		cy_nxt   = cy_q;
		stop_nxt = stopped_q;
		emit     = 1'b0;
		kind     = KIND_ASCII;
		case (q_item.op)
			OP_RESTART: begin
				cx_nxt   = ox;
				cy_nxt   = oy;
				stop_nxt = 1'b0;
			end
			OP_ASCII, OP_NEWLINE, OP_GLYPH: begin
				if (!stopped_q) begin
					cx_nxt = cx1;
					cy_nxt = cy1;
					if (area_full) begin
						stop_nxt = 1'b1;
						emit     = 1'b1;
						kind     = KIND_FULL;
					end else if (q_item.op == OP_NEWLINE) begin
						cy_nxt = cy1 + COORD_BITS'(fs);
						cx_nxt = ox + COORD_BITS'(half);
					end else if (q_item.op == OP_GLYPH) begin
						cx_nxt = cx1 + COORD_BITS'(fs);
						emit   = size_supported(fs);
						kind   = q_item.glyph_ok ? KIND_GLYPH : KIND_BLANK;
					end else begin
						cx_nxt = cx1 + COORD_BITS'(half);
						emit   = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q        <= '0;
			cy_q        <= '0;
			stopped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cur_load.load_x || cur_load.load_y) begin
				if (cur_load.load_x) cx_q <= cur_load.value[COORD_BITS-1:0];
				if (cur_load.load_y) cy_q <= cur_load.value[COORD_BITS-1:0];
			end else if (go) begin
				cx_q      <= cx_nxt;
				cy_q      <= cy_nxt;
				stopped_q <= stop_nxt;
			end
			if (go && emit) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			command_kind <= kind;
			pos_x        <= COORD_W'(cx1);
			pos_y        <= COORD_W'(cy1);
			char_code    <= (kind == KIND_ASCII) ? q_item.code : '0;
			font_offset  <= (kind == KIND_GLYPH) ? prod[OFFS_BITS-1:0] : '0;
		end
	end

	assign empty = !out_valid_q;

endmodule

// File: rtl/gta_checker.sv
`timescale 1ns / 1ps
// gta_checker: port-level checks of the glyph addresser, bound to the top level
// depends on gta_pkg and gbk_text_layout_glyph_addresser

module gta_checker import gta_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 empty,
	input logic                 pop,
	input logic [1:0]           command_kind,
	input logic [COORD_W-1:0]   pos_x,
	input logic [COORD_W-1:0]   pos_y,
	input logic [BYTE_BITS-1:0] char_code,
	input logic [OFFS_BITS-1:0] font_offset
);

	// a waiting result holds until its transfer
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(command_kind) && $stable(pos_x)
			&& $stable(pos_y) && $stable(char_code) && $stable(font_offset))
		else $error("result changed before its transfer");

	a_code_only_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && command_kind != KIND_ASCII |-> char_code == '0)
		else $error("char_code set on a non-ascii result");

	a_offset_only_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && command_kind != KIND_GLYPH |-> font_offset == '0)
		else $error("font_offset set on a non-glyph result");

	// every glyph bitmap size is a multiple of eight bytes
	a_offset_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && command_kind == KIND_GLYPH |-> font_offset[2:0] == 3'b000)
		else $error("glyph offset not aligned to eight bytes");

endmodule

bind gbk_text_layout_glyph_addresser gta_checker u_checker (.*);

// File: test/gbk_text_layout_glyph_addresser_tb.sv
`timescale 1ns / 1ps
// gbk_text_layout_glyph_addresser_tb: self-checking bench for the text layout and glyph addresser
// streams text strings under several window settings, predicts each draw command and
// checks it against the result queue; depends on gta_pkg and the rtl top level

module gbk_text_layout_glyph_addresser_tb;
	import gta_pkg::*;

	localparam int IDLE_LIMIT    = 4000;  // cycles without any transfer before giving up
	localparam int SETTLE_CYCLES = 12;    // covers the result register plus the item queue
	localparam int PHASES        = 12;
	localparam int PHASE_BYTES   = 135;
	localparam logic [2:0] REG_SPARE = 3'd7;  // top of the unused index range

	// one draw command as the result ports show it
	typedef struct packed {
		kind_t                kind;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
		logic [BYTE_BITS-1:0] code;
		logic [OFFS_BITS-1:0] offs;
	} draw_cmd_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_READY,
		RX_COIN,
		RX_EVERY_FOURTH,
		RX_TRICKLE
	} rx_mode_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 push      = 1'b0;
	logic [BYTE_BITS-1:0] text_byte = '0;
	logic                 full;
	logic                 empty;
	logic                 pop       = 1'b0;
	logic [1:0]           command_kind;
	logic [COORD_W-1:0]   pos_x;
	logic [COORD_W-1:0]   pos_y;
	logic [BYTE_BITS-1:0] char_code;
	logic [OFFS_BITS-1:0] font_offset;
	logic                 cfg_wr    = 1'b0;
	logic [2:0]           cfg_index = '0;
	logic [COORD_W-1:0]   cfg_data  = '0;

	gbk_text_layout_glyph_addresser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.text_byte    (text_byte),
		.full         (full),
		.empty        (empty),
		.pop          (pop),
		.command_kind (command_kind),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.char_code    (char_code),
		.font_offset  (font_offset),
		.cfg_wr       (cfg_wr),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// layout state kept by the bench, reset values of the block
	logic [COORD_W-1:0]   win_x0  = '0;
	logic [COORD_W-1:0]   win_y0  = '0;
	logic [COORD_W-1:0]   win_w   = 16'd240;
	logic [COORD_W-1:0]   win_h   = 16'd240;
	logic [SIZE_BITS-1:0] glyph_h = 6'd16;
	logic [COORD_W-1:0]   pen_x   = '0;
	logic [COORD_W-1:0]   pen_y   = '0;
	logic                 lead_held   = 1'b0;
	logic [BYTE_BITS-1:0] lead_code   = '0;
	logic                 layout_full = 1'b0;

	draw_cmd_t            predicted_cmds [$];  // commands still owed by the block
	logic [BYTE_BITS-1:0] outgoing_text  [$];  // bytes waiting for the driver
	int                   text_in_flight = 0;  // queued but not yet transferred
	int                   bytes_queued   = 0;
	int                   errors         = 0;

	// directed opening: ascii extremes, 0x80 as ascii, newline, first and last
	// table codes, the trail gap around 0x7f, blank codes, a newline as trail,
	// and a lead byte cut off by the end of the string
	logic [BYTE_BITS-1:0] opening_text [25] = '{
		8'h41, 8'h20, 8'h01, 8'h7f, 8'h80, CHAR_NEWLINE,
		8'h81, 8'h40, 8'hfe, 8'hfe, 8'h81, 8'h7e, 8'h81, 8'h7f, 8'h81, 8'h80,
		8'h81, 8'h3f, 8'h81, 8'hff, 8'hff, 8'h50, 8'hb0, CHAR_NEWLINE, 8'hc3
	};

	// wrap to a new line when the glyph would overflow the width; true when
	// the line passes the bottom of the window
	function automatic bit wrap_line(input int step);
		int right_edge;
		int bottom_edge;
		right_edge = int'(win_x0) + int'(win_w) - step;
		if (int'(pen_x) > right_edge) begin
			pen_y = pen_y + COORD_W'(glyph_h);
			pen_x = win_x0;
		end
		bottom_edge = int'(win_y0) + int'(win_h) - int'(glyph_h);
		return int'(pen_y) > bottom_edge;
	endfunction

	// advance the layout by one byte; true when a draw command comes out
	function automatic bit lay_out_byte(input logic [BYTE_BITS-1:0] b, output draw_cmd_t cmd);
		int sz;
		int half;
		int col;
		int row;
		int bitmap_bytes;
		logic [BYTE_BITS-1:0] qh;
		bit made;
		sz   = int'(glyph_h);
		half = sz / 2;
		made = 1'b0;
		cmd  = '0;
		if (b == CHAR_END) begin
			// end of string, also after a lead byte
			pen_x       = win_x0;
			pen_y       = win_y0;
			lead_held   = 1'b0;
			lead_code   = '0;
			layout_full = 1'b0;
		end else if (!layout_full) begin
			if (lead_held) begin
				qh        = lead_code;
				lead_held = 1'b0;
				lead_code = '0;
				if (wrap_line(sz)) begin
					layout_full = 1'b1;
					made        = 1'b1;
					cmd.kind    = KIND_FULL;
					cmd.x       = pen_x;
					cmd.y       = pen_y;
				end else begin
					// sizes without a glyph table still move the pen
					if (sz == 12 || sz == 16 || sz == 24 || sz == 32) begin
						made  = 1'b1;
						cmd.x = pen_x;
						cmd.y = pen_y;
						if (qh < LEAD_MIN || b < TRAIL_MIN || b == CODE_BAD || qh == CODE_BAD) begin
							cmd.kind = KIND_BLANK;
						end else begin
							col = (b < TRAIL_GAP) ? int'(b) - int'(TRAIL_MIN)
							                      : int'(b) - int'(TRAIL_HIGH);
							row = int'(qh) - int'(LEAD_MIN);
							bitmap_bytes = (sz / 8 + ((sz % 8 != 0) ? 1 : 0)) * sz;
							cmd.kind = KIND_GLYPH;
							cmd.offs = OFFS_BITS'((int'(ROW_STRIDE) * row + col) * bitmap_bytes);
						end
					end
					pen_x = pen_x + COORD_W'(sz);
				end
			end else if (b >= LEAD_MIN) begin
				lead_held = 1'b1;
				lead_code = b;
			end else begin
				if (wrap_line(half)) begin
					layout_full = 1'b1;
					made        = 1'b1;
					cmd.kind    = KIND_FULL;
					cmd.x       = pen_x;
					cmd.y       = pen_y;
				end else begin
					if (b == CHAR_NEWLINE) begin
						pen_y = pen_y + COORD_W'(glyph_h);
						pen_x = win_x0;
					end else begin
						made     = 1'b1;
						cmd.kind = KIND_ASCII;
						cmd.x    = pen_x;
						cmd.y    = pen_y;
						cmd.code = b;
					end
					pen_x = pen_x + COORD_W'(half);
				end
			end
		end
		return made;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
	                                    input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// one register write; the block is idle, so the bench state follows at once
	task automatic write_reg(input logic [2:0] idx, input logic [COORD_W-1:0] value);
		@(posedge clk);
		cfg_wr    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_ORIGIN_X: begin
				win_x0 = value;
				pen_x  = value;
			end
			REG_ORIGIN_Y: begin
				win_y0 = value;
				pen_y  = value;
			end
			REG_AREA_WIDTH:  win_w   = value;
			REG_AREA_HEIGHT: win_h   = value;
			REG_FONT_SIZE:   glyph_h = value[SIZE_BITS-1:0];
			default: ;
		endcase
	endtask

	// all five registers in a rotated order, after a write to an unused index
	task automatic setup_window(input int ox, input int oy, input int w, input int h,
	                            input int fs);
		int start;
		int k;
		logic [2:0] idx;
		logic [COORD_W-1:0] value;
		start = $urandom_range(0, 4);
		write_reg(3'($urandom_range(int'(REG_FONT_SIZE) + 1, int'(REG_SPARE))),
		          COORD_W'($urandom));
		for (k = 0; k < 5; k++) begin
			idx = 3'((start + k) % 5);
			case (idx)
				REG_ORIGIN_X:    value = COORD_W'(ox);
				REG_ORIGIN_Y:    value = COORD_W'(oy);
				REG_AREA_WIDTH:  value = COORD_W'(w);
				REG_AREA_HEIGHT: value = COORD_W'(h);
				default: begin
					// junk above the size field must be dropped
					value = COORD_W'($urandom);
					value[SIZE_BITS-1:0] = SIZE_BITS'(fs);
				end
			endcase
			write_reg(idx, value);
		end
		@(posedge clk);
		cfg_wr <= 1'b0;
	endtask

	task automatic queue_byte(input logic [BYTE_BITS-1:0] b);
		outgoing_text.push_back(b);
		text_in_flight++;
		bytes_queued++;
	endtask

	// a string of ascii, newlines and gbk pairs with some noise; most end in zero
	task automatic queue_string(input int len);
		int k;
		int pick;
		for (k = 0; k < len; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				queue_byte(BYTE_BITS'($urandom_range(1, 128)));
			end else if (pick < 60) begin
				queue_byte(CHAR_NEWLINE);
			end else if (pick < 92) begin
				queue_byte(($urandom_range(0, 15) == 0) ? CODE_BAD
				           : BYTE_BITS'($urandom_range(int'(LEAD_MIN), 254)));
				queue_byte(($urandom_range(0, 4) == 0) ? BYTE_BITS'($urandom_range(1, 255))
				           : BYTE_BITS'($urandom_range(int'(TRAIL_MIN), 254)));
			end else begin
				queue_byte(BYTE_BITS'($urandom_range(1, 255)));
			end
		end
		if ($urandom_range(0, 7) != 0)
			queue_byte(CHAR_END);
	endtask

	// every byte transferred and every command back, then let the tail settle
	task automatic wait_drained();
		do @(negedge clk); while (text_in_flight != 0 || predicted_cmds.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender: bursts of random length from the byte queue with random gaps
	int        burst_left = 0;
	int        gap_left   = 0;
	draw_cmd_t sent_cmd;

	always @(posedge clk) begin
		if (arst_n) begin
			// a transfer on the input side moves the layout on
			if (push && !full) begin
				if (lay_out_byte(text_byte, sent_cmd))
					predicted_cmds.push_back(sent_cmd);
				text_in_flight--;
			end
			// hold the byte while full, otherwise pick the next one
			if (!(push && full)) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 12);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
				if (burst_left > 0 && outgoing_text.size() > 0) begin
					push      <= 1'b1;
					text_byte <= outgoing_text.pop_front();
					burst_left--;
				end else begin
					push <= 1'b0;
					if (burst_left == 0 && gap_left > 0)
						gap_left--;
				end
			end
		end
	end

	// receiver: compare each transfer with the oldest owed command, then
	// choose pop for the next cycle from the current stall pattern
	rx_mode_t  rx_mode  = RX_READY;
	int        rx_count = 0;
	draw_cmd_t owed_cmd;

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (predicted_cmds.size() == 0) begin
					$display("%0t: unexpected result, expected none actual kind %0d at %0d,%0d",
					         $time, command_kind, pos_x, pos_y);
					errors++;
				end else begin
					owed_cmd = predicted_cmds.pop_front();
					check_field("command_kind", int'(owed_cmd.kind), command_kind);
					check_field("pos_x", owed_cmd.x, pos_x);
					check_field("pos_y", owed_cmd.y, pos_y);
					check_field("char_code", owed_cmd.code, char_code);
					check_field("font_offset", owed_cmd.offs, font_offset);
				end
			end
			if (rx_count == 0) begin
				rx_mode  = rx_mode_t'($urandom_range(0, 3));
				rx_count = $urandom_range(16, 96);
			end
			rx_count--;
			case (rx_mode)
				RX_READY:        pop <= 1'b1;
				RX_COIN:         pop <= 1'($urandom_range(0, 1));
				RX_EVERY_FOURTH: pop <= (rx_count % 4 == 0);
				default:         pop <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// watchdog on cycles without any transfer or register write
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || cfg_wr)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("[gbk_text_layout_glyph_addresser] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		int ox;
		int oy;
		int w;
		int h;
		int fs;
		int target;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under the reset settings
		foreach (opening_text[k])
			queue_byte(opening_text[k]);
		queue_byte(CHAR_END);
		wait_drained();

		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					// empty window: full at the first character
					ox = 0; oy = 0; w = 0; h = 0; fs = 12;
				end
				1: begin
					// top corner of the coordinate space, pen wraps around
					ox = 65535; oy = 65535; w = 65535; h = 65535; fs = 32;
				end
				2: begin
					// size with no glyph table, small window for wraps and full
					ox = 10; oy = 20; w = 60; h = 50; fs = 13;
				end
				3: begin
					ox = 0; oy = 0; w = 65535; h = 65535; fs = 12;
				end
				default: begin
					fs = ($urandom_range(0, 9) < 7) ? (($urandom_range(0, 3) + 1) * 8)
					                                : $urandom_range(12, 32);
					if (fs == 8)
						fs = 12;
					case ($urandom_range(0, 7))
						0:       ox = 0;
						1:       ox = 65535 - $urandom_range(0, 100);
						default: ox = $urandom_range(0, 300);
					endcase
					oy = ($urandom_range(0, 7) == 0) ? 65535 - $urandom_range(0, 100)
					                                 : $urandom_range(0, 300);
					w  = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(fs, 400);
					h  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(fs, 300);
				end
			endcase
			setup_window(ox, oy, w, h, fs);

			// strings until this phase has its share of bytes
			target = bytes_queued + PHASE_BYTES;
			while (bytes_queued < target)
				queue_string(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40));
			queue_byte(CHAR_END);
			wait_drained();
		end

		if (errors == 0 && predicted_cmds.size() == 0)
			$display("[gbk_text_layout_glyph_addresser] OK");
		else
			$display("[gbk_text_layout_glyph_addresser] ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/gta_pkg.sv
rtl/gta_queue.sv
rtl/gta_front.sv
rtl/gta_back.sv
rtl/gbk_text_layout_glyph_addresser.sv
rtl/gta_checker.sv
test/gbk_text_layout_glyph_addresser_tb.sv
